@@ rtl/core/lpht_pkg.sv @@
package lpht_pkg;

	localparam int SLOT_DEPTH = 1024;
	localparam int KEY_BYTES  = 8;

	localparam int SLOT_AW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
	localparam int CAP_W   = $clog2(SLOT_DEPTH + 1);
	localparam int KEY_W   = 64;
	localparam int VAL_W   = 32;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;
	localparam int RIDX_W  = ADDR_W - 2;

	// byte sum of the key, and the remainder unit that works on it two bits a cycle
	localparam int SUM_W     = $clog2(KEY_BYTES * 255 + 1);
	localparam int DIV_STEPS = (SUM_W + 1) / 2;
	localparam int DIV_W     = 2 * DIV_STEPS;
	localparam int DCNT_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 8) ? {KEY_W{1'b1}} :
		KEY_W'((65'd1 << (8 * KEY_BYTES)) - 65'd1);

	localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);
	localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(SLOT_DEPTH);
	localparam logic [CAP_W-1:0] CAP_RESET = (SLOT_DEPTH < 1024) ? CAP_W'(SLOT_DEPTH) :
		CAP_W'(1024);

	localparam logic [RIDX_W-1:0] REG_CAP = RIDX_W'(0);

	typedef logic [1:0] opcode_t;
	localparam opcode_t OP_INSERT = 2'd0;
	localparam opcode_t OP_SEARCH = 2'd1;
	localparam opcode_t OP_REMOVE = 2'd2;

	typedef logic [2:0] status_t;
	localparam status_t ST_INSERTED = 3'd0;
	localparam status_t ST_UPDATED  = 3'd1;
	localparam status_t ST_FULL     = 3'd2;
	localparam status_t ST_FOUND    = 3'd3;
	localparam status_t ST_NOTFOUND = 3'd4;
	localparam status_t ST_REMOVED  = 3'd5;
	localparam status_t ST_MISSED   = 3'd6;

	typedef logic [1:0] mark_t;
	localparam mark_t MARK_EMPTY = 2'd0;
	localparam mark_t MARK_USED  = 2'd1;
	localparam mark_t MARK_GONE  = 2'd2;

	typedef struct packed {
		opcode_t                  opcode;
		logic [KEY_W-1:0]         key;
		logic signed [VAL_W-1:0]  value;
	} item_t;

	typedef struct packed {
		status_t          status;
		logic [CAP_W-1:0] entry_count;
	} result_t;

	typedef struct packed {
		mark_t             mark;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

endpackage

@@ rtl/core/lpht_ram.sv @@
module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/lpht_home.sv @@
module lpht_home (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lpht_pkg::KEY_W-1:0] key,
	input  logic [lpht_pkg::CAP_W-1:0] cap,
	output logic                       done,
	output logic [lpht_pkg::SLOT_AW-1:0] home
);
	import lpht_pkg::*;

	logic [DIV_W-1:0]  sum_q;
	logic [CAP_W-1:0]  rem_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              run_q;
	logic              done_q;
	logic [SUM_W-1:0]  bsum;
	logic [CAP_W-1:0]  rem_a;
	logic [CAP_W-1:0]  rem_b;

	// one restoring step: shift in a dividend bit, subtract the divisor if it fits
	function automatic logic [CAP_W-1:0] rem_step(input logic [CAP_W-1:0] r, input logic b,
			input logic [CAP_W-1:0] d);
		logic [CAP_W:0] t;
		t = {r, b};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
		end
		return t[CAP_W-1:0];
	endfunction

	always_comb begin
		bsum = '0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			bsum = bsum + SUM_W'(key[8*i +: 8]);
		end
	end

	assign rem_a = rem_step(rem_q, sum_q[DIV_W-1], cap);
	assign rem_b = rem_step(rem_a, sum_q[DIV_W-2], cap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + DCNT_W'(1);
				if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sum_q <= DIV_W'(bsum);
			rem_q <= '0;
		end else if (run_q) begin
			sum_q <= sum_q << 2;
			rem_q <= rem_b;
		end
	end

	assign done = done_q;
	assign home = rem_q[SLOT_AW-1:0];

endmodule

@@ rtl/core/linear_probe_hash_table.sv @@
// An insert refused as full gives its result the cycle after it is taken.
// Other items: the remainder unit first finds the home slot, then slots are probed one per cycle,
// from 1 up to capacity of them, until the done strobe.
// Throughput: one item at a time; the next item can be taken the cycle the result shows.
// Reset: the slot memory is swept empty, one slot per cycle, busy held high;
// the capacity register may be written during the sweep.
module linear_probe_hash_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lpht_pkg::ADDR_W-1:0] paddr,
	input  logic [lpht_pkg::DATA_W-1:0] pwdata,
	output logic [lpht_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        start,
	output logic                        busy,
	input  lpht_pkg::item_t             item,
	output logic                        done,
	output lpht_pkg::result_t           result
);
	import lpht_pkg::*;

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_HOME  = 2'd2;
	localparam logic [1:0] S_LOOK  = 2'd3;

	logic [1:0]         state_q;
	logic [SLOT_AW-1:0] clr_q;
	logic [CAP_W-1:0]   cap_q;
	logic [CAP_W-1:0]   count_q;
	logic               done_q;
	result_t            result_q;
	item_t              item_q;
	logic [SLOT_AW-1:0] cur_q;
	logic [CAP_W-1:0]   n_q;
	logic               have_q;
	logic [SLOT_AW-1:0] tgt_q;

	logic               accept;
	logic               full;
	logic               cfg_we;
	logic [CAP_W-1:0]   cfg_v;
	logic               home_start;
	logic               home_done;
	logic [SLOT_AW-1:0] home;

	logic               ram_we;
	logic [SLOT_AW-1:0] ram_wa;
	slot_t              ram_wd;
	logic               ram_re;
	logic [SLOT_AW-1:0] ram_ra;
	slot_t              rd;

	logic [CAP_W-1:0]   cur_inc;
	logic [SLOT_AW-1:0] nxt;
	logic               last;
	logic               hit;
	logic               lk_fin;
	status_t            lk_st;
	logic               lk_we;
	logic [SLOT_AW-1:0] lk_wa;
	slot_t              lk_wd;
	logic [CAP_W-1:0]   lk_cnt;
	logic               lk_tgt;
	slot_t              new_slot;

	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1:2] == REG_CAP) ? DATA_W'(cap_q) : '0;

	assign cfg_we = psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_CAP
		&& count_q == '0;

	always_comb begin
		cfg_v = pwdata[CAP_W-1:0];
		if (cfg_v < CAP_MIN) begin
			cfg_v = CAP_MIN;
		end else if (cfg_v > CAP_MAX) begin
			cfg_v = CAP_MAX;
		end
	end

	assign busy       = state_q != S_IDLE;
	assign accept     = start && !busy;
	assign full       = ({1'b0, count_q} + (CAP_W+1)'(1)) >= {1'b0, cap_q};
	assign home_start = accept && !(item.opcode == OP_INSERT && full);

	lpht_home u_home (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (home_start),
		.key    (item.key & KEY_MASK),
		.cap    (cap_q),
		.done   (home_done),
		.home   (home)
	);

	// probe walk: data for cur_q is on rd while the read of the next slot goes out
	assign cur_inc  = {1'b0, cur_q} + CAP_W'(1);
	assign nxt      = (cur_inc >= cap_q) ? '0 : cur_inc[SLOT_AW-1:0];
	assign last     = ({1'b0, n_q} + (CAP_W+1)'(1)) == {1'b0, cap_q};
	assign hit      = rd.mark == MARK_USED && rd.key == item_q.key;
	assign new_slot = '{mark: MARK_USED, key: item_q.key, value: item_q.value};

	always_comb begin
		lk_fin = 1'b0;
		lk_st  = ST_NOTFOUND;
		lk_we  = 1'b0;
		lk_wa  = cur_q;
		lk_wd  = new_slot;
		lk_cnt = count_q;
		lk_tgt = 1'b0;
		unique case (item_q.opcode)
			OP_INSERT: begin
				if (hit) begin
					lk_fin = 1'b1;
					lk_we  = 1'b1;
					lk_st  = ST_UPDATED;
				end else if (rd.mark == MARK_GONE) begin
					lk_tgt = !have_q;
					if (last) begin
						lk_fin = 1'b1;
						lk_we  = 1'b1;
						lk_wa  = have_q ? tgt_q : cur_q;
						lk_cnt = count_q + CAP_W'(1);
						lk_st  = ST_INSERTED;
					end
				end else if (rd.mark != MARK_USED) begin
					lk_fin = 1'b1;
					lk_we  = 1'b1;
					lk_wa  = have_q ? tgt_q : cur_q;
					lk_cnt = count_q + CAP_W'(1);
					lk_st  = ST_INSERTED;
				end else if (last) begin
					lk_fin = 1'b1;
					lk_we  = have_q;
					lk_wa  = tgt_q;
					if (have_q) begin
						lk_cnt = count_q + CAP_W'(1);
						lk_st  = ST_INSERTED;
					end else begin
						lk_st = ST_FULL;
					end
				end
			end
			OP_REMOVE: begin
				if (hit) begin
					lk_fin = 1'b1;
					lk_we  = 1'b1;
					lk_wd  = '{mark: MARK_GONE, key: rd.key, value: rd.value};
					lk_cnt = count_q - CAP_W'(1);
					lk_st  = ST_REMOVED;
				end else if (rd.mark == MARK_EMPTY || last) begin
					lk_fin = 1'b1;
					lk_st  = ST_MISSED;
				end
			end
			default: begin
				if (hit) begin
					lk_fin = 1'b1;
					lk_st  = ST_FOUND;
				end else if (rd.mark == MARK_EMPTY || last) begin
					lk_fin = 1'b1;
					lk_st  = ST_NOTFOUND;
				end
			end
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_wa = lk_wa;
		ram_wd = lk_wd;
		ram_re = 1'b0;
		ram_ra = nxt;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_wa = clr_q;
				ram_wd = '0;
			end
			S_HOME: begin
				ram_re = home_done;
				ram_ra = home;
			end
			S_LOOK: begin
				ram_we = lk_we;
				ram_re = !lk_fin;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	lpht_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (SLOT_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.re    (ram_re),
		.raddr (ram_ra),
		.rdata (rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			cap_q   <= CAP_RESET;
			count_q <= '0;
			done_q  <= 1'b0;
			have_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				cap_q <= cfg_v;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SLOT_AW'(1);
					if (clr_q == SLOT_AW'(SLOT_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (home_start) begin
							state_q <= S_HOME;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_HOME: begin
					if (home_done) begin
						have_q  <= 1'b0;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (lk_tgt) begin
						have_q <= 1'b1;
					end
					if (lk_fin) begin
						count_q <= lk_cnt;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q   <= '{opcode: item.opcode, key: item.key & KEY_MASK, value: item.value};
			result_q <= '{status: ST_FULL, entry_count: count_q};
		end
		if (state_q == S_HOME && home_done) begin
			cur_q <= home;
			n_q   <= '0;
		end
		if (state_q == S_LOOK) begin
			cur_q <= nxt;
			n_q   <= n_q + CAP_W'(1);
			if (lk_tgt) begin
				tgt_q <= cur_q;
			end
			if (lk_fin) begin
				result_q <= '{status: lk_st, entry_count: lk_cnt};
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ rtl/core/lpht_chk.sv @@
module lpht_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic              pready,
	input lpht_pkg::result_t result
);
	import lpht_pkg::*;

	// an accepted item either finishes at once or keeps the block busy
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted item neither busy nor done");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.status <= ST_MISSED)
		else $error("status code out of range");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.entry_count < CAP_MAX)
		else $error("entry count reached capacity limit");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind linear_probe_hash_table lpht_chk u_lpht_chk (.*);
